// ===== src/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// tce_pkg: shared types, constants and tables of the channel effect engine
// Holds the item structs, the effect codes, the note table and the wave tables.
// ----------------------------------------------------------------------------
package tce_pkg;

   localparam int CHANNELS   = 4;
   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int WAVE_LEN   = 64;
   localparam int POS_W      = $clog2(WAVE_LEN);
   localparam int NOTE_COUNT = 36;
   localparam logic [15:0] PERIOD_MAX = 16'd856;
   localparam logic [15:0] PERIOD_MIN = 16'd113;

   // effect command nibbles
   localparam logic [3:0] FX_ARP    = 4'h0;
   localparam logic [3:0] FX_UP     = 4'h1;
   localparam logic [3:0] FX_DOWN   = 4'h2;
   localparam logic [3:0] FX_PORTA  = 4'h3;
   localparam logic [3:0] FX_VIB    = 4'h4;
   localparam logic [3:0] FX_PORTAV = 4'h5;
   localparam logic [3:0] FX_VIBV   = 4'h6;
   localparam logic [3:0] FX_TREM   = 4'h7;
   localparam logic [3:0] FX_VSLIDE = 4'hA;
   localparam logic [3:0] FX_SETVOL = 4'hC;
   localparam logic [3:0] FX_EXT    = 4'hE;

   // extended sub commands
   localparam logic [3:0] EX_FUP   = 4'h1;
   localparam logic [3:0] EX_FDOWN = 4'h2;
   localparam logic [3:0] EX_VWAVE = 4'h4;
   localparam logic [3:0] EX_TWAVE = 4'h7;
   localparam logic [3:0] EX_FVUP  = 4'hA;
   localparam logic [3:0] EX_FVDN  = 4'hB;

   typedef struct packed {
      logic [1:0]  chan;
      logic [4:0]  tick_num;
      logic        row_end;
      logic [11:0] note_period;
      logic [4:0]  sample_num;
      logic [6:0]  sample_vol;
      logic [3:0]  effect_code;
      logic [7:0]  effect_arg;
   } req_type;

   typedef struct packed {
      logic [1:0] out_chan;
      logic [9:0] play_period;
      logic [6:0] play_vol;
      logic       note_trigger;
      logic       silent;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [3:0]       speed;
      logic [3:0]       depth;
      logic [3:0]       wave;
   } osc_type;

   // classified item passed from front to back
   typedef struct packed {
      req_type    req;
      logic       row_start;
      logic [5:0] arp_idx;
      logic       arp_hit;
   } cmd_type;

   function automatic logic [9:0] note_at(input logic [5:0] idx);
      logic [5:0] i;
      i = (idx > 6'd35) ? 6'd35 : idx;
      case (i)
         6'd0: note_at = 10'd856;  6'd1: note_at = 10'd808;  6'd2: note_at = 10'd762;
         6'd3: note_at = 10'd720;  6'd4: note_at = 10'd678;  6'd5: note_at = 10'd640;
         6'd6: note_at = 10'd604;  6'd7: note_at = 10'd570;  6'd8: note_at = 10'd538;
         6'd9: note_at = 10'd508;  6'd10: note_at = 10'd480; 6'd11: note_at = 10'd453;
         6'd12: note_at = 10'd428; 6'd13: note_at = 10'd404; 6'd14: note_at = 10'd381;
         6'd15: note_at = 10'd360; 6'd16: note_at = 10'd339; 6'd17: note_at = 10'd320;
         6'd18: note_at = 10'd302; 6'd19: note_at = 10'd285; 6'd20: note_at = 10'd269;
         6'd21: note_at = 10'd254; 6'd22: note_at = 10'd240; 6'd23: note_at = 10'd226;
         6'd24: note_at = 10'd214; 6'd25: note_at = 10'd202; 6'd26: note_at = 10'd190;
         6'd27: note_at = 10'd180; 6'd28: note_at = 10'd170; 6'd29: note_at = 10'd160;
         6'd30: note_at = 10'd151; 6'd31: note_at = 10'd143; 6'd32: note_at = 10'd135;
         6'd33: note_at = 10'd127; 6'd34: note_at = 10'd120;
         default: note_at = 10'd113;
      endcase
   endfunction

   function automatic logic [6:0] quarter_sine(input logic [4:0] q);
      case (q)
         5'd0: quarter_sine = 7'd0;    5'd1: quarter_sine = 7'd12;
         5'd2: quarter_sine = 7'd24;   5'd3: quarter_sine = 7'd36;
         5'd4: quarter_sine = 7'd48;   5'd5: quarter_sine = 7'd59;
         5'd6: quarter_sine = 7'd70;   5'd7: quarter_sine = 7'd80;
         5'd8: quarter_sine = 7'd89;   5'd9: quarter_sine = 7'd98;
         5'd10: quarter_sine = 7'd105; 5'd11: quarter_sine = 7'd112;
         5'd12: quarter_sine = 7'd117; 5'd13: quarter_sine = 7'd121;
         5'd14: quarter_sine = 7'd124; 5'd15: quarter_sine = 7'd126;
         default: quarter_sine = 7'd127;
      endcase
   endfunction

   // signed wave sample: sine, saw, square, random falls back to sine
   function automatic logic signed [7:0] wave_at(input logic [3:0] wave,
                                                  input logic [5:0] pos);
      logic [4:0]  q;
      logic [4:0]  qi;
      logic [6:0]  s;
      logic [13:0] ramp;
      q  = pos[4:0];
      qi = (q <= 5'd16) ? q : 5'(6'd32 - {1'b0, q});
      s  = quarter_sine(qi);
      case (wave[1:0])
         2'd1: begin
            if (!pos[5]) begin
               ramp = 14'd255 * {8'd0, pos};
               wave_at = -$signed({1'b0, ramp[12:6]});
            end else begin
               ramp = 14'd255 * {7'd0, 7'd64 - {1'b0, pos}};
               wave_at = $signed({1'b0, ramp[12:6]});
            end
         end
         2'd2: begin
            ramp = '0;
            wave_at = pos[5] ? -8'sd127 : 8'sd127;
         end
         default: begin
            ramp = '0;
            wave_at = pos[5] ? -$signed({1'b0, s}) : $signed({1'b0, s});
         end
      endcase
   endfunction

endpackage

// ===== src/tce_if.sv =====
// ----------------------------------------------------------------------------
// tce_req_if / tce_rsp_if: valid-ready channels of the effect engine
// One interface per channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface tce_req_if;
   logic             valid;
   logic             ready;
   tce_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tce_rsp_if;
   logic             valid;
   logic             ready;
   tce_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tce_front.sv =====
// ----------------------------------------------------------------------------
// tce_front: accept and classify items
// Registers each item with its row-start flag and the arpeggio note lookup
// of the cell period, then offers it to the queue.
// ----------------------------------------------------------------------------
module tce_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  tce_pkg::req_type    in_data,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output tce_pkg::cmd_type    cmd_data
);
   import tce_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic [5:0] idx;
   logic       hit;

   // search the note table for the cell period (independent compares)
   always_comb begin
      idx = '0;
      hit = 1'b0;
      for (int i = NOTE_COUNT - 1; i >= 0; i--) begin
         if ({2'b0, note_at(6'(i))} == in_data.note_period) begin
            idx = 6'(i);
            hit = 1'b1;
         end
      end
   end

   assign in_ready = !valid_ff || cmd_ready;

   // classify the item
   always_comb begin
      cmd_in           = cmd_ff;
      valid_in         = valid_ff && !cmd_ready;
      if (in_valid && in_ready) begin
         valid_in         = 1'b1;
         cmd_in.req       = in_data;
         cmd_in.row_start = (in_data.tick_num == 5'd0);
         cmd_in.arp_idx   = idx;
         cmd_in.arp_hit   = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;
endmodule

// ===== src/tce_queue.sv =====
// ----------------------------------------------------------------------------
// tce_queue: short queue between front and back
// Two entries, so front and back stall on their own.
// ----------------------------------------------------------------------------
module tce_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  tce_pkg::cmd_type wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output tce_pkg::cmd_type rd_data
);
   import tce_pkg::*;

   cmd_type    mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // advance pointers and count
   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) mem_ff[wptr_ff] <= wr_data;
   end
endmodule

// ===== src/tce_back.sv =====
// ----------------------------------------------------------------------------
// tce_back: carry out the effect of one tick on the channel state
// Reads and writes the per-channel state in the cycle an item is taken and
// registers the result in an output stage.
// ----------------------------------------------------------------------------
module tce_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  tce_pkg::cmd_type cmd_data,
   output logic             out_valid,
   input  logic             out_ready,
   output tce_pkg::rsp_type out_data
);
   import tce_pkg::*;

   logic [15:0] base_ff [CHANNELS];
   logic [15:0] shown_ff [CHANNELS];
   logic [15:0] target_ff [CHANNELS];
   logic [7:0]  speed_ff [CHANNELS];
   logic [6:0]  level_ff [CHANNELS];
   logic [6:0]  saved_ff [CHANNELS];
   logic [15:0] arp_ff [CHANNELS][3];
   osc_type     vib_ff [CHANNELS];
   osc_type     trem_ff [CHANNELS];
   logic        has_ff [CHANNELS];
   logic        stop_ff [CHANNELS];
   logic        valid_ff;
   rsp_type     rsp_ff;

   logic [15:0] base_n, shown_n, target_n, per_out;
   logic [7:0]  speed_n;
   logic [6:0]  level_n, saved_n, vol_out;
   logic [15:0] arp_n [3];
   osc_type     vib_n, trem_n;
   logic        has_n, stop_n, trig, take, arp_wr;
   logic [CH_W-1:0] ch;
   req_type     r;
   logic [3:0]  lo, hi;
   logic signed [9:0]  vol;
   logic signed [7:0]  w;
   logic signed [12:0] prod;
   logic signed [12:0] delta;
   logic [7:0]  wmag;
   logic [11:0] tmag;
   logic [16:0] diff;
   logic [5:0]  aidx;
   logic [1:0]  tmod;

   // tick number modulo three from the bit weights 1, 2, 1, 2, 1
   function automatic logic [1:0] mod3(input logic [4:0] t);
      logic [2:0] s;
      s = 3'(t[0]) + 3'(t[2]) + 3'(t[4]) + {1'b0, t[1], 1'b0} + {1'b0, t[3], 1'b0};
      if (s inside {3'd0, 3'd3, 3'd6})      mod3 = 2'd0;
      else if (s inside {3'd1, 3'd4, 3'd7}) mod3 = 2'd1;
      else                                  mod3 = 2'd2;
   endfunction

   assign take      = cmd_valid && cmd_ready;
   assign cmd_ready = !valid_ff || out_ready;
   assign r   = cmd_data.req;
   assign ch  = CH_W'(r.chan % CHANNELS);
   assign lo  = r.effect_arg[3:0];
   assign hi  = r.effect_arg[7:4];
   assign tmod = mod3(r.tick_num);

   function automatic logic signed [9:0] vslide(input logic signed [9:0] v,
                                                 input logic [7:0] a);
      if (a[7:4] != 4'd0) vslide = v + $signed({6'd0, a[7:4]});
      else                vslide = v - $signed({2'd0, a});
   endfunction

   // run the effect of the item
   always_comb begin
      base_n   = base_ff[ch];
      shown_n  = shown_ff[ch];
      target_n = target_ff[ch];
      speed_n  = speed_ff[ch];
      saved_n  = saved_ff[ch];
      for (int k = 0; k < 3; k++) arp_n[k] = arp_ff[ch][k];
      vib_n    = vib_ff[ch];
      trem_n   = trem_ff[ch];
      has_n    = has_ff[ch];
      stop_n   = stop_ff[ch];
      vol      = $signed({3'd0, level_ff[ch]});
      trig     = 1'b0;
      arp_wr   = 1'b0;
      w        = '0;
      prod     = '0;
      delta    = '0;
      wmag     = '0;
      tmag     = '0;
      diff     = '0;
      aidx     = '0;
      if (cmd_data.row_start) begin
         if (r.sample_num != 5'd0) begin
            stop_n = 1'b0;
            has_n  = 1'b1;
            vol    = $signed({3'd0, r.sample_vol});
         end
         if (r.note_period != 12'd0) begin
            if (r.effect_code != FX_PORTA && r.effect_code != FX_PORTAV) begin
               base_n  = {4'd0, r.note_period};
               shown_n = {4'd0, r.note_period};
               stop_n  = 1'b0;
               trig    = 1'b1;
            end
            target_n = {4'd0, r.note_period};
         end
         case (r.effect_code)
            FX_ARP: begin
               if (r.effect_arg != 8'd0) begin
                  base_n = target_n;
                  // target equals the cell period when one is given
                  if (r.note_period != 12'd0) begin
                     arp_wr = cmd_data.arp_hit;
                     aidx   = cmd_data.arp_idx;
                  end else begin
                     for (int i = NOTE_COUNT - 1; i >= 0; i--) begin
                        if ({6'd0, note_at(6'(i))} == target_n) begin
                           aidx   = 6'(i);
                           arp_wr = 1'b1;
                        end
                     end
                  end
                  if (arp_wr) begin
                     arp_n[0] = base_n;
                     arp_n[1] = {6'd0, note_at(6'(aidx + hi))};
                     arp_n[2] = {6'd0, note_at(6'(aidx + lo))};
                  end
               end
            end
            FX_PORTA: if (r.effect_arg != 8'd0) speed_n = r.effect_arg;
            FX_VIB: begin
               if (r.effect_arg != 8'd0) begin
                  vib_n.depth = lo;
                  vib_n.speed = hi;
               end
               if (!vib_n.wave[2]) vib_n.pos = '0;
            end
            FX_TREM: begin
               saved_n = 7'(vol);
               if (r.effect_arg != 8'd0) begin
                  trem_n.depth = lo;
                  trem_n.speed = hi;
               end
               if (!trem_n.wave[2]) trem_n.pos = '0;
            end
            FX_SETVOL: vol = (r.effect_arg > 8'd64) ? 10'sd64 : $signed({2'd0, r.effect_arg});
            FX_EXT: begin
               case (hi)
                  EX_FUP: begin
                     base_n  = 16'(base_n - {12'd0, lo});
                     shown_n = base_n;
                  end
                  EX_FDOWN: begin
                     base_n  = 16'(base_n + {12'd0, lo});
                     shown_n = base_n;
                  end
                  EX_FVUP: vol = vol + $signed({6'd0, lo});
                  EX_FVDN: vol = vol - $signed({6'd0, lo});
                  default: ;
               endcase
            end
            default: ;
         endcase
         if (shown_n == 16'd0 || !has_n) stop_n = 1'b1;
      end else begin
         case (r.effect_code)
            FX_ARP: if (r.effect_arg != 8'd0) shown_n = arp_n[tmod];
            FX_UP: begin
               base_n  = 16'(base_n - {8'd0, r.effect_arg});
               shown_n = base_n;
            end
            FX_DOWN: begin
               base_n  = 16'(base_n + {8'd0, r.effect_arg});
               shown_n = base_n;
            end
            FX_PORTA, FX_PORTAV: begin
               if (r.effect_code == FX_PORTAV) vol = vslide(vol, r.effect_arg);
               diff = (target_n > base_n) ? 17'(target_n - base_n)
                                          : 17'(base_n - target_n);
               if (diff < {9'd0, speed_n}) base_n = target_n;
               else if (target_n > base_n) base_n = 16'(base_n + {8'd0, speed_n});
               else                        base_n = 16'(base_n - {8'd0, speed_n});
               shown_n = base_n;
            end
            FX_VIB, FX_VIBV: begin
               if (r.effect_code == FX_VIBV) vol = vslide(vol, r.effect_arg);
               w     = wave_at(vib_n.wave, vib_n.pos);
               prod  = $signed({9'd0, vib_n.depth}) * 13'(w);
               delta = prod >>> 7;
               shown_n = 16'(base_n + 16'(delta));
               vib_n.pos = 6'(vib_n.pos + {2'd0, vib_n.speed});
            end
            FX_TREM: begin
               w    = wave_at(trem_n.wave, trem_n.pos);
               wmag = w[7] ? 8'(-w) : 8'(w);
               tmag = {8'd0, trem_n.depth} * {4'd0, wmag};
               vol  = w[7] ? $signed({3'd0, saved_n}) - $signed({4'd0, tmag[11:6]})
                           : $signed({3'd0, saved_n}) + $signed({4'd0, tmag[11:6]});
               trem_n.pos = 6'(trem_n.pos + {2'd0, trem_n.speed});
            end
            FX_VSLIDE: vol = vslide(vol, r.effect_arg);
            FX_EXT: begin
               if (hi == EX_VWAVE)      vib_n.wave  = lo;
               else if (hi == EX_TWAVE) trem_n.wave = lo;
            end
            default: ;
         endcase
      end
      // clamp volume and period
      if (vol < 0)        vol_out = 7'd0;
      else if (vol > 64)  vol_out = 7'd64;
      else                vol_out = 7'(vol);
      if (shown_n > PERIOD_MAX)      per_out = PERIOD_MAX;
      else if (shown_n < PERIOD_MIN) per_out = PERIOD_MIN;
      else                           per_out = shown_n;
      level_n = vol_out;
      if (r.row_end) begin
         shown_n = base_n;
         if (r.effect_code == FX_TREM) level_n = saved_n;
      end else begin
         shown_n = per_out;
      end
   end

   // write back channel state and register the result
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            base_ff[c]   <= '0;
            shown_ff[c]  <= '0;
            target_ff[c] <= '0;
            speed_ff[c]  <= '0;
            level_ff[c]  <= '0;
            saved_ff[c]  <= '0;
            for (int k = 0; k < 3; k++) arp_ff[c][k] <= '0;
            vib_ff[c]    <= '0;
            trem_ff[c]   <= '0;
            has_ff[c]    <= 1'b0;
            stop_ff[c]   <= 1'b1;
         end
      end else begin
         if (take) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
         if (take) begin
            base_ff[ch]   <= base_n;
            shown_ff[ch]  <= shown_n;
            target_ff[ch] <= target_n;
            speed_ff[ch]  <= speed_n;
            level_ff[ch]  <= level_n;
            saved_ff[ch]  <= saved_n;
            for (int k = 0; k < 3; k++) arp_ff[ch][k] <= arp_n[k];
            vib_ff[ch]    <= vib_n;
            trem_ff[ch]   <= trem_n;
            has_ff[ch]    <= has_n;
            stop_ff[ch]   <= stop_n;
         end
      end
      if (take) begin
         rsp_ff.out_chan     <= 2'(ch);
         rsp_ff.play_period  <= per_out[9:0];
         rsp_ff.play_vol     <= vol_out;
         rsp_ff.note_trigger <= trig;
         rsp_ff.silent       <= stop_n;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;
endmodule

// ===== src/tracker_channel_effects.sv =====
// ----------------------------------------------------------------------------
// tracker_channel_effects: per-channel effect engine of a four-channel tracker
// Front stage, two-entry queue and back stage with channel state.
// ----------------------------------------------------------------------------
// One item (one tick of one channel) is taken per clock cycle when the result
// side keeps up; the item passes the front register and the queue entry, and
// its result is registered in the output register of the back stage, from
// which it can be taken. The rate is set by the back stage, which reads and
// writes a channel's state in the cycle it takes an item, so consecutive ticks
// of the same channel follow each other without a gap.
module tracker_channel_effects (
   input  logic clock,
   input  logic reset,
   tce_req_if.sink   req,
   tce_rsp_if.source rsp
);
   import tce_pkg::*;

   logic    f_valid, f_ready, q_valid, q_ready;
   cmd_type f_data, q_data;

   tce_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
   );

   tce_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
   );

   tce_back u_back (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule

// ===== src/tce_checker.sv =====
// ----------------------------------------------------------------------------
// tce_props: port-level checks of the effect engine
// Watches the result channel for range and stall behavior.
// ----------------------------------------------------------------------------
module tce_props (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tce_pkg::rsp_type rsp_data
);
   import tce_pkg::*;

   // hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // keep period in range
   a_per: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.play_period >= 10'd113 && rsp_data.play_period <= 10'd856)
      else $error("period out of range");

   // keep volume in range
   a_vol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.play_vol <= 7'd64)
      else $error("volume out of range");

   // drop any result during reset
   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind tracker_channel_effects tce_props u_tce_props (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
